>>> hw/rtl/polyline_pose_resampler_macros.svh
// assertion macros for the polyline pose resampler
// included by the modules that carry concurrent assertions
`ifndef POLYLINE_POSE_RESAMPLER_MACROS_SVH
`define POLYLINE_POSE_RESAMPLER_MACROS_SVH

// same-cycle implication
`define PPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppr assertion failed");

// next-cycle implication
`define PPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppr assertion failed");

`endif

>>> hw/rtl/ppr_pkg.sv
// shared types and constants of the polyline pose resampler
// no dependencies
package ppr_pkg;

   localparam int CORDIC_ITERS = 30;
   localparam int CORDIC_WIDTH = 36;
   localparam int ITER_IDX_WIDTH = 5;
   localparam int SQ_WIDTH = 46;
   localparam int MUL_WIDTH = 22;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int STEP_WIDTH = 16;
   localparam int STRIDE_WIDTH = 8;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STEP_LENGTH = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EMIT_STRIDE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REVERSE = 2'd2;

   localparam logic [STEP_WIDTH-1:0] STEP_RESET = 16'd115;
   localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = 8'd50;

   localparam logic [32:0] LONG_LIMIT = 33'h000400000;
   localparam logic [CORDIC_WIDTH-1:0] NORM_LO = 36'h020000000;
   localparam logic [CORDIC_WIDTH-1:0] NORM_HI = 36'h040000000;
   localparam logic [31:0] HALF_TURN = 32'h80000000;

   localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef enum logic [1:0] {
      CD_IDLE,
      CD_NORM,
      CD_ITER
   } cordic_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SQR,
      BK_SUM,
      BK_SEARCH,
      BK_DIV,
      BK_WAITC,
      BK_EMIT,
      BK_END,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic [31:0] phase;
   } cordic_status_type;

endpackage

>>> hw/rtl/ppr_cordic.sv
// iterative vectoring cordic: normalizes, then one rotation per cycle
// depends on ppr_pkg
module ppr_cordic #(
   parameter int DW = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [DW-1:0]          dx,
   input  logic signed [DW-1:0]          dy,
   output ppr_pkg::cordic_status_type    status
);

   localparam int W = ppr_pkg::CORDIC_WIDTH;

   ppr_pkg::cordic_state_type state_ff, state_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] z_ff, z_in;
   logic [ppr_pkg::ITER_IDX_WIDTH-1:0] i_ff, i_in;
   logic signed [W-1:0] ex, ey, ay, mx, xsh, ysh;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppr_pkg::CD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      i_in = i_ff;
      ex = W'(dx);
      ey = W'(dy);
      ay = (y_ff < 0) ? -y_ff : y_ff;
      mx = (x_ff > ay) ? x_ff : ay;
      xsh = x_ff >>> i_ff;
      ysh = y_ff >>> i_ff;
      unique case (state_ff)
         ppr_pkg::CD_IDLE: begin
            if (start) begin
               if (dx < 0) begin
                  x_in = -ex;
                  y_in = -ey;
                  z_in = ppr_pkg::HALF_TURN;
               end else begin
                  x_in = ex;
                  y_in = ey;
                  z_in = '0;
               end
               state_in = ppr_pkg::CD_NORM;
            end
         end
         ppr_pkg::CD_NORM: begin
            i_in = '0;
            if (mx < $signed(ppr_pkg::NORM_LO)) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else if (mx >= $signed(ppr_pkg::NORM_HI)) begin
               x_in = x_ff >>> 1;
               y_in = y_ff >>> 1;
            end else begin
               state_in = ppr_pkg::CD_ITER;
            end
         end
         ppr_pkg::CD_ITER: begin
            if (y_ff > 0) begin
               x_in = x_ff + ysh;
               y_in = y_ff - xsh;
               z_in = z_ff + ppr_pkg::ATAN_TAB[i_ff];
            end else begin
               x_in = x_ff - ysh;
               y_in = y_ff + xsh;
               z_in = z_ff - ppr_pkg::ATAN_TAB[i_ff];
            end
            i_in = i_ff + 1'b1;
            if (i_ff == ppr_pkg::ITER_IDX_WIDTH'(ppr_pkg::CORDIC_ITERS - 1)) begin
               state_in = ppr_pkg::CD_IDLE;
            end
         end
         default: begin
            state_in = ppr_pkg::CD_IDLE;
         end
      endcase
   end

   assign status.busy = (state_ff != ppr_pkg::CD_IDLE);
   assign status.phase = z_ff;

endmodule

>>> hw/rtl/ppr_queue.sv
// two-entry queue between the vertex front end and the segment engine
// no dependencies
module ppr_queue #(
   parameter int EW = 98
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [EW-1:0] wdata,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output logic [EW-1:0] rdata
);

   logic [EW-1:0] slot_ff [2];
   logic wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

   assign full = cnt_ff[1];
   assign valid = (cnt_ff != 2'd0);
   assign rdata = slot_ff[rptr_ff];

endmodule

>>> hw/rtl/ppr_front.sv
// vertex front end: takes vertex transactions, tracks the previous vertex
// and classifies polyline starts; depends on nothing
module ppr_front #(
   parameter int C = 24,
   parameter int IW = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IW-1:0]     req_tdata,
   input  logic              req_tlast,
   input  logic              req_tuser,
   input  logic              q_full,
   output logic              q_push,
   output logic [4*C+1:0]    q_wdata
);

   logic [C-1:0] prev_x_ff, prev_y_ff;
   logic have_prev_ff;
   logic [C-1:0] cx, cy;
   logic start;

   assign cx = req_tdata[C-1:0];
   assign cy = req_tdata[2*C-1:C];
   assign start = req_tuser | ~have_prev_ff;
   assign req_tready = ~q_full;
   assign q_push = req_tvalid & ~q_full;
   assign q_wdata = {req_tlast, start, cy, cx, prev_y_ff, prev_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (q_push) begin
         have_prev_ff <= ~req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         prev_x_ff <= cx;
         prev_y_ff <= cy;
      end
   end

endmodule

>>> hw/rtl/ppr_back.sv
// segment engine: subdivision search, per-axis divide, heading, dense
// point walk, endpoint and result staging; depends on ppr_pkg, ppr_cordic and the macros header
`include "polyline_pose_resampler_macros.svh"
module ppr_back #(
   parameter int C = 24,
   parameter int A = 16,
   parameter int MAXN = 63,
   parameter int OW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ppr_pkg::STEP_WIDTH-1:0]      step_length,
   input  logic [ppr_pkg::STRIDE_WIDTH-1:0]    emit_stride,
   input  logic                                reverse_heading,
   input  logic                                q_valid,
   input  logic [4*C+1:0]                      q_rdata,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [OW-1:0]                       rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);

   localparam int NW = $clog2(MAXN + 1);
   localparam int DCW = $clog2(C);
   localparam int SQW = ppr_pkg::SQ_WIDTH;
   localparam int MW = ppr_pkg::MUL_WIDTH;

   ppr_pkg::back_state_type state_ff, state_in;
   ppr_pkg::cordic_status_type cst;

   logic signed [C-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic start_ff, last_ff;
   logic sgx_ff, sgx_in, sgy_ff, sgy_in;
   logic [C-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [2*MW-1:0] axx_ff, axx_in, ayy_ff, ayy_in;
   logic [2*ppr_pkg::STEP_WIDTH-1:0] st2_ff, st2_in;
   logic [SQW-1:0] l2_ff, l2_in, sq_ff, sq_in, d_ff, d_in;
   logic [NW-1:0] t_ff, t_in, n_ff, n_in, k_ff, k_in;
   logic clamp_ff, clamp_in;
   logic [NW-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [C-1:0] q0x_ff, q0x_in, q0y_ff, q0y_in;
   logic [DCW-1:0] dc_ff, dc_in;
   logic [C-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [NW:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [ppr_pkg::STRIDE_WIDTH-1:0] phase_ff, phase_in;
   logic [A-1:0] head_ff, head_in;
   logic [C-1:0] emx_ff, emx_in, emy_ff, emy_in;
   logic anyem_ff, anyem_in;
   logic stg_v_ff, stg_v_in;
   logic [C-1:0] stx_ff, stx_in, sty_ff, sty_in;
   logic [A-1:0] sth_ff, sth_in;
   logic stc_ff, stc_in;
   logic ov_ff, ov_in;
   logic [C-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [A-1:0] oh_ff, oh_in;
   logic ol_ff, ol_in, oc_ff, oc_in;

   logic signed [C:0] dx, dy;
   logic seg_go;
   logic out_free, can_put, put;
   logic [C-1:0] put_x, put_y;
   logic [A-1:0] put_h;
   logic put_c;
   logic [NW:0] tx, ty, two_n;
   logic [NW+1:0] rsx, rsy;
   logic [31:0] hsum;
   logic [A-1:0] rev_add;
   logic end_put;

   assign dx = (C+1)'(cx_ff) - (C+1)'(px_ff);
   assign dy = (C+1)'(cy_ff) - (C+1)'(py_ff);
   assign seg_go = (state_ff == ppr_pkg::BK_LOAD) && !start_ff && ((dx != 0) || (dy != 0));

   ppr_cordic #(.DW(C + 1)) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(seg_go),
      .dx(dx),
      .dy(dy),
      .status(cst)
   );

   assign out_free = !ov_ff || rsp_tready;
   assign can_put = !stg_v_ff || out_free;
   assign two_n = {n_ff, 1'b0};
   assign tx = {remx_ff, ax_ff[dc_ff]};
   assign ty = {remy_ff, ay_ff[dc_ff]};
   assign rsx = (NW+2)'(rx_ff) + (NW+2)'({remx_ff, 1'b0});
   assign rsy = (NW+2)'(ry_ff) + (NW+2)'({remy_ff, 1'b0});
   assign hsum = cst.phase + (32'd1 << (31 - A));
   assign rev_add = reverse_heading ? {1'b1, {(A-1){1'b0}}} : '0;
   assign end_put = last_ff && !start_ff && (emit_stride != '0) &&
                    ((phase_ff == '0) || !anyem_ff || (emx_ff != cx_ff) || (emy_ff != cy_ff));

   always_comb begin
      state_in = state_ff;
      sgx_in = sgx_ff;
      sgy_in = sgy_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      axx_in = axx_ff;
      ayy_in = ayy_ff;
      st2_in = st2_ff;
      l2_in = l2_ff;
      sq_in = sq_ff;
      d_in = d_ff;
      t_in = t_ff;
      n_in = n_ff;
      k_in = k_ff;
      clamp_in = clamp_ff;
      remx_in = remx_ff;
      remy_in = remy_ff;
      q0x_in = q0x_ff;
      q0y_in = q0y_ff;
      dc_in = dc_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      phase_in = phase_ff;
      head_in = head_ff;
      q_pop = 1'b0;
      put = 1'b0;
      put_x = sgx_ff ? (px_ff - qx_ff) : (px_ff + qx_ff);
      put_y = sgy_ff ? (py_ff - qy_ff) : (py_ff + qy_ff);
      put_h = head_ff + rev_add;
      put_c = clamp_ff;
      unique case (state_ff)
         ppr_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               state_in = ppr_pkg::BK_LOAD;
            end
         end
         ppr_pkg::BK_LOAD: begin
            sgx_in = dx[C];
            sgy_in = dy[C];
            ax_in = dx[C] ? C'(-dx) : C'(dx);
            ay_in = dy[C] ? C'(-dy) : C'(dy);
            clamp_in = 1'b0;
            if (start_ff) begin
               phase_in = '0;
               head_in = '0;
               state_in = ppr_pkg::BK_END;
            end else if (seg_go) begin
               state_in = ppr_pkg::BK_SQR;
            end else begin
               state_in = ppr_pkg::BK_END;
            end
         end
         ppr_pkg::BK_SQR: begin
            axx_in = MW'(ax_ff) * MW'(ax_ff);
            ayy_in = MW'(ay_ff) * MW'(ay_ff);
            st2_in = step_length * step_length;
            clamp_in = !((33'(ax_ff) < ppr_pkg::LONG_LIMIT) &&
                         (33'(ay_ff) < ppr_pkg::LONG_LIMIT));
            state_in = ppr_pkg::BK_SUM;
         end
         ppr_pkg::BK_SUM: begin
            l2_in = SQW'(axx_ff) + SQW'(ayy_ff);
            sq_in = SQW'(st2_ff);
            d_in = SQW'(st2_ff);
            t_in = NW'(1);
            remx_in = '0;
            remy_in = '0;
            dc_in = DCW'(C - 1);
            if (clamp_ff) begin
               n_in = NW'(MAXN);
               state_in = ppr_pkg::BK_DIV;
            end else begin
               state_in = ppr_pkg::BK_SEARCH;
            end
         end
         ppr_pkg::BK_SEARCH: begin
            if (sq_ff >= l2_ff) begin
               n_in = t_ff;
               state_in = ppr_pkg::BK_DIV;
            end else if (t_ff == NW'(MAXN)) begin
               n_in = NW'(MAXN);
               clamp_in = 1'b1;
               state_in = ppr_pkg::BK_DIV;
            end else begin
               d_in = d_ff + (SQW'(st2_ff) << 1);
               sq_in = sq_ff + d_ff + (SQW'(st2_ff) << 1);
               t_in = t_ff + 1'b1;
            end
         end
         ppr_pkg::BK_DIV: begin
            if (tx >= (NW+1)'(n_ff)) begin
               remx_in = NW'(tx - (NW+1)'(n_ff));
               q0x_in[dc_ff] = 1'b1;
            end else begin
               remx_in = tx[NW-1:0];
               q0x_in[dc_ff] = 1'b0;
            end
            if (ty >= (NW+1)'(n_ff)) begin
               remy_in = NW'(ty - (NW+1)'(n_ff));
               q0y_in[dc_ff] = 1'b1;
            end else begin
               remy_in = ty[NW-1:0];
               q0y_in[dc_ff] = 1'b0;
            end
            dc_in = dc_ff - 1'b1;
            qx_in = '0;
            qy_in = '0;
            rx_in = (NW+1)'(n_ff);
            ry_in = (NW+1)'(n_ff);
            k_in = '0;
            if (dc_ff == '0) begin
               state_in = ppr_pkg::BK_WAITC;
            end
         end
         ppr_pkg::BK_WAITC: begin
            if (!cst.busy) begin
               head_in = hsum[31 -: A];
               state_in = (emit_stride == '0) ? ppr_pkg::BK_END : ppr_pkg::BK_EMIT;
            end
         end
         ppr_pkg::BK_EMIT: begin
            if (!(phase_ff == '0 && !can_put)) begin
               put = (phase_ff == '0);
               phase_in = ((9'(phase_ff) + 9'd1) >= 9'(emit_stride)) ? '0 : phase_ff + 1'b1;
               k_in = k_ff + 1'b1;
               if (rsx >= (NW+2)'(two_n)) begin
                  rx_in = (NW+1)'(rsx - (NW+2)'(two_n));
                  qx_in = qx_ff + q0x_ff + 1'b1;
               end else begin
                  rx_in = (NW+1)'(rsx);
                  qx_in = qx_ff + q0x_ff;
               end
               if (rsy >= (NW+2)'(two_n)) begin
                  ry_in = (NW+1)'(rsy - (NW+2)'(two_n));
                  qy_in = qy_ff + q0y_ff + 1'b1;
               end else begin
                  ry_in = (NW+1)'(rsy);
                  qy_in = qy_ff + q0y_ff;
               end
               if (k_ff == n_ff - 1'b1) begin
                  state_in = ppr_pkg::BK_END;
               end
            end
         end
         ppr_pkg::BK_END: begin
            put_x = cx_ff;
            put_y = cy_ff;
            put_c = 1'b0;
            if (!end_put) begin
               state_in = ppr_pkg::BK_FLUSH;
            end else if (can_put) begin
               put = 1'b1;
               state_in = ppr_pkg::BK_FLUSH;
            end
         end
         ppr_pkg::BK_FLUSH: begin
            if (!stg_v_ff || out_free) begin
               state_in = ppr_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ppr_pkg::BK_IDLE;
         end
      endcase
   end

   // staging holds the newest pose until it is known whether it ends the transaction
   always_comb begin
      stg_v_in = stg_v_ff;
      stx_in = stx_ff;
      sty_in = sty_ff;
      sth_in = sth_ff;
      stc_in = stc_ff;
      ov_in = ov_ff && !rsp_tready;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oh_in = oh_ff;
      ol_in = ol_ff;
      oc_in = oc_ff;
      emx_in = emx_ff;
      emy_in = emy_ff;
      anyem_in = anyem_ff;
      if (state_ff == ppr_pkg::BK_LOAD && start_ff) begin
         anyem_in = 1'b0;
         emx_in = '0;
         emy_in = '0;
      end
      if (put) begin
         if (stg_v_ff) begin
            ov_in = 1'b1;
            ox_in = stx_ff;
            oy_in = sty_ff;
            oh_in = sth_ff;
            oc_in = stc_ff;
            ol_in = 1'b0;
         end
         stg_v_in = 1'b1;
         stx_in = put_x;
         sty_in = put_y;
         sth_in = put_h;
         stc_in = put_c;
         emx_in = put_x;
         emy_in = put_y;
         anyem_in = 1'b1;
      end else if (state_ff == ppr_pkg::BK_FLUSH && stg_v_ff && out_free) begin
         ov_in = 1'b1;
         ox_in = stx_ff;
         oy_in = sty_ff;
         oh_in = sth_ff;
         oc_in = stc_ff;
         ol_in = 1'b1;
         stg_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppr_pkg::BK_IDLE;
         stg_v_ff <= 1'b0;
         ov_ff <= 1'b0;
         anyem_ff <= 1'b0;
         phase_ff <= '0;
         head_ff <= '0;
      end else begin
         state_ff <= state_in;
         stg_v_ff <= stg_v_in;
         ov_ff <= ov_in;
         anyem_ff <= anyem_in;
         phase_ff <= phase_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         px_ff <= q_rdata[C-1:0];
         py_ff <= q_rdata[2*C-1:C];
         cx_ff <= q_rdata[3*C-1:2*C];
         cy_ff <= q_rdata[4*C-1:3*C];
         start_ff <= q_rdata[4*C];
         last_ff <= q_rdata[4*C+1];
      end
      sgx_ff <= sgx_in;
      sgy_ff <= sgy_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      axx_ff <= axx_in;
      ayy_ff <= ayy_in;
      st2_ff <= st2_in;
      l2_ff <= l2_in;
      sq_ff <= sq_in;
      d_ff <= d_in;
      t_ff <= t_in;
      n_ff <= n_in;
      k_ff <= k_in;
      clamp_ff <= clamp_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      q0x_ff <= q0x_in;
      q0y_ff <= q0y_in;
      dc_ff <= dc_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      emx_ff <= emx_in;
      emy_ff <= emy_in;
      stx_ff <= stx_in;
      sty_ff <= sty_in;
      sth_ff <= sth_in;
      stc_ff <= stc_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oh_ff <= oh_in;
      ol_ff <= ol_in;
      oc_ff <= oc_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = OW'({oh_ff, oy_ff, ox_ff});
   assign rsp_tlast = ol_ff;
   assign rsp_tuser = oc_ff;

   `PPR_ASSERT_IMP(a_emit_n_range, clock, reset, state_ff == ppr_pkg::BK_EMIT, n_ff != '0 && n_ff <= NW'(MAXN))
   `PPR_ASSERT_IMP(a_emit_k_below_n, clock, reset, state_ff == ppr_pkg::BK_EMIT, k_ff < n_ff)
   `PPR_ASSERT_IMP(a_emit_rem_bound, clock, reset, state_ff == ppr_pkg::BK_EMIT, rx_ff < two_n && ry_ff < two_n)
   `PPR_ASSERT_IMP(a_emit_after_cordic, clock, reset, state_ff == ppr_pkg::BK_EMIT, !cst.busy)
   `PPR_ASSERT_NXT(a_pop_loads, clock, reset, q_pop, state_ff == ppr_pkg::BK_LOAD)

endmodule

>>> hw/rtl/polyline_pose_resampler.sv
// Polyline pose resampler: each vertex transaction closes the segment from the previous
// vertex; the segment is split into n equal parts (smallest n with n*step_length covering
// its length, at most MAX_SEGMENT_STEPS), and every emit_stride-th dense point leaves as a
// pose with the segment heading, the final vertex adding the endpoint. A front end takes
// vertices into a two-entry queue; one segment engine works on one vertex at a time. A
// vertex with a non-degenerate segment runs the subdivision search, a per-axis divide over
// COORD_WIDTH quotient bits, the wait for the heading cordic (normalizing shifts and 30
// rotations) and the dense point walk, one dense point per cycle while the output accepts poses.
module polyline_pose_resampler #(
   parameter int COORD_WIDTH = 24,
   parameter int ANGLE_WIDTH = 16,
   parameter int MAX_SEGMENT_STEPS = 63
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // vertex_x, vertex_y
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   // first_vertex
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pose_x, pose_y, pose_heading
   output logic [((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast,
   // steps_clamped
   output logic rsp_tuser,
   input  logic csr_wen,
   input  logic [ppr_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ppr_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int IW = ((2*COORD_WIDTH+7)/8)*8;
   localparam int OW = ((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8;
   localparam int EW = 4*COORD_WIDTH+2;

   logic [ppr_pkg::STEP_WIDTH-1:0] step_ff;
   logic [ppr_pkg::STRIDE_WIDTH-1:0] stride_ff;
   logic rev_ff;
   logic q_full, q_push, q_pop, q_valid;
   logic [EW-1:0] q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ppr_pkg::STEP_RESET;
         stride_ff <= ppr_pkg::STRIDE_RESET;
         rev_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            ppr_pkg::CSR_STEP_LENGTH: step_ff <= csr_wdata;
            ppr_pkg::CSR_EMIT_STRIDE: stride_ff <= csr_wdata[ppr_pkg::STRIDE_WIDTH-1:0];
            ppr_pkg::CSR_REVERSE: rev_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ppr_front #(.C(COORD_WIDTH), .IW(IW)) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tuser(req_tuser),
      .q_full(q_full),
      .q_push(q_push),
      .q_wdata(q_wdata)
   );

   ppr_queue #(.EW(EW)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .wdata(q_wdata),
      .full(q_full),
      .pop(q_pop),
      .valid(q_valid),
      .rdata(q_rdata)
   );

   ppr_back #(
      .C(COORD_WIDTH),
      .A(ANGLE_WIDTH),
      .MAXN(MAX_SEGMENT_STEPS),
      .OW(OW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .step_length(step_ff),
      .emit_stride(stride_ff),
      .reverse_heading(rev_ff),
      .q_valid(q_valid),
      .q_rdata(q_rdata),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule

>>> sim/polyline_pose_resampler_checker.sv
// pose checker for the polyline pose resampler: watches the vertex, pose and csr ports,
// predicts every pose from its own model of the block and compares field by field
// depends on ppr_pkg
`timescale 1ns / 100ps

module polyline_pose_resampler_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [47:0] req_tdata,
   input  logic req_tlast,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic rsp_tlast,
   input  logic rsp_tuser,
   input  logic csr_wen,
   input  logic [ppr_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ppr_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output int fail_count,
   output int pending
);

   localparam int MAX_STEPS = 63;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] heading;
      logic last;
      logic clamped;
   } pose_type;

   pose_type expected_poses[$];
   pose_type step_poses[$];

   logic [15:0] step_length = ppr_pkg::STEP_RESET;
   logic [7:0] emit_stride = ppr_pkg::STRIDE_RESET;
   logic reverse = 1'b0;

   longint prev_x, prev_y, emitted_x, emitted_y;
   logic have_prev, any_emitted;
   int stride_phase;
   logic [15:0] last_heading;

   assign pending = expected_poses.size();

   function automatic logic [15:0] heading_of(longint x, longint y);
      logic [31:0] z;
      longint m, xs, ys;
      z = 32'h0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = ppr_pkg::HALF_TURN;
      end
      m = x;
      if ((y < 0 ? -y : y) > m) m = (y < 0 ? -y : y);
      while (m < 64'sd536870912) begin
         x = x * 2;
         y = y * 2;
         m = m * 2;
      end
      while (m >= 64'sd1073741824) begin
         x = x >>> 1;
         y = y >>> 1;
         m = m >>> 1;
      end
      for (int i = 0; i < ppr_pkg::CORDIC_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ppr_pkg::ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ppr_pkg::ATAN_TAB[i];
         end
      end
      z = z + 32'h00008000;
      return z[31:16];
   endfunction

   function automatic longint lerp(longint a, longint d, int k, int n);
      longint mag, off;
      mag = d < 0 ? -d : d;
      off = (2 * mag * k + n) / (2 * n);
      return d < 0 ? a - off : a + off;
   endfunction

   function automatic void add_pose(longint x, longint y, logic [15:0] h, logic clamped);
      pose_type p;
      p.x = x[23:0];
      p.y = y[23:0];
      p.heading = h + (reverse ? 16'h8000 : 16'h0);
      p.last = 1'b0;
      p.clamped = clamped;
      step_poses.insert(step_poses.size(), p);
      emitted_x = x;
      emitted_y = y;
      any_emitted = 1'b1;
   endfunction

   function automatic void predict_vertex(longint cx, longint cy, logic first, logic last);
      logic start;
      longint dx, dy, ax, ay, l2, s;
      int n;
      logic clamped;
      pose_type p;
      start = first || !have_prev;
      step_poses.delete();
      if (start) begin
         stride_phase = 0;
         last_heading = 16'h0;
         emitted_x = 0;
         emitted_y = 0;
         any_emitted = 1'b0;
      end else begin
         dx = cx - prev_x;
         dy = cy - prev_y;
         if (dx != 0 || dy != 0) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            n = MAX_STEPS;
            clamped = 1'b1;
            if (ax < 64'sd4194304 && ay < 64'sd4194304) begin
               l2 = ax * ax + ay * ay;
               for (int t = 1; t <= MAX_STEPS; t++) begin
                  s = t * longint'(step_length);
                  if (s * s >= l2) begin
                     n = t;
                     clamped = 1'b0;
                     break;
                  end
               end
            end
            last_heading = heading_of(dx, dy);
            for (int k = 0; k < n; k++) begin
               if (emit_stride != 0) begin
                  if (stride_phase == 0)
                     add_pose(lerp(prev_x, dx, k, n), lerp(prev_y, dy, k, n),
                              last_heading, clamped);
                  stride_phase = (stride_phase + 1 >= emit_stride) ? 0 : stride_phase + 1;
               end
            end
         end
      end
      prev_x = cx;
      prev_y = cy;
      have_prev = 1'b1;
      if (last) begin
         if (!start && emit_stride != 0 && (stride_phase == 0 || !any_emitted ||
             emitted_x != cx || emitted_y != cy))
            add_pose(cx, cy, last_heading, 1'b0);
         have_prev = 1'b0;
      end
      if (step_poses.size() > 0) step_poses[step_poses.size()-1].last = 1'b1;
      foreach (step_poses[i]) begin
         p = step_poses[i];
         expected_poses.insert(expected_poses.size(), p);
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      prev_x = 0;
      prev_y = 0;
      emitted_x = 0;
      emitted_y = 0;
      have_prev = 1'b0;
      any_emitted = 1'b0;
      stride_phase = 0;
      last_heading = 16'h0;
   end

   always @(posedge clock) begin
      pose_type want;
      if (!reset) begin
         if (csr_wen) begin
            case (csr_index)
               ppr_pkg::CSR_STEP_LENGTH: step_length <= csr_wdata;
               ppr_pkg::CSR_EMIT_STRIDE: emit_stride <= csr_wdata[7:0];
               ppr_pkg::CSR_REVERSE: reverse <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_vertex(longint'($signed(req_tdata[23:0])),
                           longint'($signed(req_tdata[47:24])), req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_poses.size() == 0) begin
               report("unexpected pose transaction", rsp_tdata, 0);
            end else begin
               want = expected_poses.pop_front();
               if (rsp_tdata[23:0] !== want.x) report("pose_x", rsp_tdata[23:0], want.x);
               if (rsp_tdata[47:24] !== want.y) report("pose_y", rsp_tdata[47:24], want.y);
               if (rsp_tdata[63:48] !== want.heading)
                  report("pose_heading", rsp_tdata[63:48], want.heading);
               if (rsp_tlast !== want.last) report("run_last", rsp_tlast, want.last);
               if (rsp_tuser !== want.clamped)
                  report("steps_clamped", rsp_tuser, want.clamped);
            end
         end
      end
   end

endmodule

>>> sim/polyline_pose_resampler_tb.sv
// testbench top for the polyline pose resampler: drives directed and random polylines
// with bursty vertex traffic and a stalling pose sink, gives the verdict
// depends on ppr_pkg, polyline_pose_resampler and polyline_pose_resampler_checker
`timescale 1ns / 100ps

module polyline_pose_resampler_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_wen = 1'b0;
   logic [ppr_pkg::CSR_IDX_WIDTH-1:0] csr_index = ppr_pkg::CSR_STEP_LENGTH;
   logic [ppr_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   int fail_count;
   int pending;
   int cycles = 0;
   int burst_left = 0;
   int cur_step = 115;

   polyline_pose_resampler dut (.*);

   polyline_pose_resampler_checker pose_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("polyline_pose_resampler_tb: FAIL");
         $finish;
      end
   end

   // sink stall pattern steps through four modes chosen by bits 7:6 of the cycle counter
   always @(posedge clock) begin
      case (cycles[7:6])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycles[2:0] != 3'd5);
      endcase
   end

   task automatic send_vertex(longint x, longint y, logic first, logic last);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y[23:0], x[23:0]};
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (2000) @(posedge clock);
   endtask

   task automatic write_csr(logic [ppr_pkg::CSR_IDX_WIDTH-1:0] idx, int value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      if (idx == ppr_pkg::CSR_STEP_LENGTH) cur_step = value & 16'hffff;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic random_polyline(output int sent);
      int count;
      longint x, y, span;
      count = $urandom_range(1, 8);
      x = $signed(24'($urandom));
      y = $signed(24'($urandom));
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            case ($urandom_range(0, 9))
               0: ;
               1: begin
                  x = $signed(24'($urandom));
                  y = $signed(24'($urandom));
               end
               default: begin
                  span = longint'(cur_step == 0 ? 1 : cur_step) * $urandom_range(0, 20) + 1;
                  x = x + $urandom_range(0, 2 * span) - span;
                  y = y + $urandom_range(0, 2 * span) - span;
               end
            endcase
         end
         send_vertex(x, y, (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                     i == count - 1);
      end
      sent = count;
   endtask

   initial begin
      int items;
      int sent;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_vertex(7, 7, 1, 1);
      wait_idle();
      write_csr(ppr_pkg::CSR_STEP_LENGTH, 115);
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 1);
      write_csr(ppr_pkg::CSR_REVERSE, 0);
      send_vertex(0, 0, 1, 0);
      send_vertex(1000, 0, 0, 0);
      send_vertex(1000, 0, 0, 0);
      send_vertex(1000, -2000, 0, 1);
      send_vertex(-8388608, -8388608, 1, 0);
      send_vertex(8388607, 8388607, 0, 0);
      send_vertex(-8388608, 8388607, 0, 1);
      send_vertex(5, 5, 0, 0);
      send_vertex(5, 5, 0, 1);
      wait_idle();
      write_csr(ppr_pkg::CSR_REVERSE, 1);
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 3);
      write_csr(ppr_pkg::CSR_STEP_LENGTH, 1);
      send_vertex(0, 0, 1, 0);
      send_vertex(100, 37, 0, 0);
      send_vertex(50, 50, 0, 1);
      wait_idle();
      write_csr(ppr_pkg::CSR_STEP_LENGTH, 0);
      send_vertex(10, 10, 1, 0);
      send_vertex(-20, 30, 0, 1);
      wait_idle();
      write_csr(ppr_pkg::CSR_STEP_LENGTH, 115);
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 0);
      send_vertex(0, 0, 1, 0);
      send_vertex(900, 900, 0, 1);
      wait_idle();
      // stride lowered in the middle of a polyline
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 7);
      send_vertex(0, 0, 1, 0);
      send_vertex(600, -300, 0, 0);
      wait_idle();
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 2);
      send_vertex(1200, -100, 0, 1);
      wait_idle();
      write_csr(ppr_pkg::CSR_STEP_LENGTH, 65535);
      write_csr(ppr_pkg::CSR_EMIT_STRIDE, 255);
      write_csr(ppr_pkg::CSR_REVERSE, 0);
      send_vertex(-4000000, 100, 1, 0);
      send_vertex(4000000, -100, 0, 1);
      wait_idle();

      // random phases
      items = 0;
      while (items < 150) begin
         case ($urandom_range(0, 3))
            0: write_csr(ppr_pkg::CSR_STEP_LENGTH, 1);
            1: write_csr(ppr_pkg::CSR_STEP_LENGTH, 65535);
            default: write_csr(ppr_pkg::CSR_STEP_LENGTH, $urandom_range(16, 2000));
         endcase
         case ($urandom_range(0, 5))
            0: write_csr(ppr_pkg::CSR_EMIT_STRIDE, 255);
            1: write_csr(ppr_pkg::CSR_EMIT_STRIDE, 1);
            default: write_csr(ppr_pkg::CSR_EMIT_STRIDE, $urandom_range(1, 6));
         endcase
         write_csr(ppr_pkg::CSR_REVERSE, $urandom_range(0, 1));
         for (int p = 0; p < 6 && items < 150; p++) begin
            random_polyline(sent);
            items += sent;
         end
         wait_idle();
      end

      if (fail_count == 0)
         $display("polyline_pose_resampler_tb: PASS");
      else
         $display("polyline_pose_resampler_tb: FAIL");
      $finish;
   end

endmodule
